// File: rtl/integer_to_ascii_formatter_defines.svh
// Assertion macros used by the formatter datapath (itaf_dp).
// The assertions use the clk_i and rst_ni ports of the module that uses them.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ITAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itaf: implication check failed");
`define ITAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itaf: next-cycle check failed");
`else
`define ITAF_ASSERT_IMP(lbl, ante, cons)
`define ITAF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/itaf_pkg.sv
`default_nettype none
package itaf_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned IN_VALUE_BITS  = 32;
  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned CHAR_BITS      = 8;

  localparam logic [CHAR_BITS-1:0] CHR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHR_PERCENT = 8'h25;
  localparam logic [CHAR_BITS-1:0] CHR_MINUS   = 8'h2d;

  typedef enum logic [OP_BITS-1:0] {
    OP_CHAR    = 2'd0,
    OP_PERCENT = 2'd1,
    OP_SDEC    = 2'd2,
    OP_UBIN    = 2'd3
  } itaf_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_SIGN,
    ST_CONV,
    ST_DEC,
    ST_BIN
  } itaf_state_e;

  typedef struct packed {
    logic load;
    logic emit_single;
    logic emit_minus;
    logic conv;
    logic dec_step;
    logic bin_step;
  } itaf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_neg;
    logic cnt_one;
    logic dec_skip;
    logic bin_skip;
  } itaf_sts_t;

endpackage
`default_nettype wire

// File: rtl/itaf_if.sv
`default_nettype none
interface itaf_req_if import itaf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_BITS-1:0]       operation;
  logic [IN_VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface itaf_chr_if import itaf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/itaf_ctrl.sv
`default_nettype none
module itaf_ctrl import itaf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  input  wire itaf_op_e  req_op_i,
  output logic           req_ready_o,
  input  wire itaf_sts_t sts_i,
  output itaf_cmd_t      cmd_o
);

  itaf_state_e state_q, state_d;
  logic        dec_go, bin_go;

  assign dec_go = sts_i.dec_skip || sts_i.out_free;
  assign bin_go = sts_i.bin_skip || sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_op_i) inside
            OP_CHAR, OP_PERCENT: state_d = ST_SINGLE;
            OP_SDEC:             state_d = sts_i.in_neg ? ST_SIGN : ST_CONV;
            OP_UBIN:             state_d = ST_BIN;
            default:             state_d = ST_SINGLE;
          endcase
        end
      end
      ST_SINGLE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_SIGN: begin
        if (sts_i.out_free) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (sts_i.cnt_one) state_d = ST_DEC;
      end
      ST_DEC: begin
        if (dec_go && sts_i.cnt_one) state_d = ST_IDLE;
      end
      ST_BIN: begin
        if (bin_go && sts_i.cnt_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_SINGLE: cmd_o.emit_single = sts_i.out_free;
      ST_SIGN:   cmd_o.emit_minus  = sts_i.out_free;
      ST_CONV:   cmd_o.conv        = 1'b1;
      ST_DEC:    cmd_o.dec_step    = dec_go;
      ST_BIN:    cmd_o.bin_step    = bin_go;
      default:   cmd_o             = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/itaf_dp.sv
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"
module itaf_dp import itaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire itaf_op_e                 op_i,
  input  wire logic [IN_VALUE_BITS-1:0] value_i,
  input  wire itaf_cmd_t                cmd_i,
  output itaf_sts_t                     sts_o,
  output logic                          out_valid_o,
  output logic [CHAR_BITS-1:0]          out_character_o,
  output logic                          out_last_o,
  input  wire logic                     out_ready_i
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned ND = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BW = 4 * ND;
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  logic [W-1:0]         bin_q, bin_d;
  logic [BW-1:0]        bcd_q, bcd_d, bcd_adj;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 started_q, started_d;
  logic                 ovalid_q, ovalid_d;
  logic [CHAR_BITS-1:0] chr_q, chr_d;
  logic                 last_q, last_d;
  logic                 wr;
  logic [W-1:0]         in_val, in_mag, load_val;
  logic [3:0]           top_dig;
  logic                 cnt_one, out_free;

  assign in_val   = W'(value_i);
  assign in_mag   = in_val[W-1] ? W'(~in_val + W'(1)) : in_val;
  assign top_dig  = bcd_q[BW-1 -: 4];
  assign cnt_one  = (cnt_q == CW'(1));
  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    unique case (op_i)
      OP_CHAR:    load_val = in_val;
      OP_PERCENT: load_val = W'(CHR_PERCENT);
      OP_SDEC:    load_val = in_mag;
      OP_UBIN:    load_val = in_val;
      default:    load_val = in_val;
    endcase
  end

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.out_free = out_free;
    sts_o.in_neg   = in_val[W-1];
    sts_o.cnt_one  = cnt_one;
    sts_o.dec_skip = !started_q && (top_dig == 4'd0) && !cnt_one;
    sts_o.bin_skip = !started_q && !bin_q[W-1] && !cnt_one;
  end

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    chr_d     = chr_q;
    last_d    = last_q;
    wr        = 1'b0;
    if (cmd_i.load) begin
      bin_d     = load_val;
      bcd_d     = '0;
      cnt_d     = CW'(W);
      started_d = 1'b0;
    end
    if (cmd_i.emit_single) begin
      wr     = 1'b1;
      chr_d  = bin_q[CHAR_BITS-1:0];
      last_d = 1'b1;
    end
    if (cmd_i.emit_minus) begin
      wr     = 1'b1;
      chr_d  = CHR_MINUS;
      last_d = 1'b0;
    end
    if (cmd_i.conv) begin
      bcd_d = {bcd_adj[BW-2:0], bin_q[W-1]};
      bin_d = {bin_q[W-2:0], 1'b0};
      cnt_d = cnt_one ? CW'(ND) : cnt_q - CW'(1);
    end
    if (cmd_i.dec_step) begin
      bcd_d = {bcd_q[BW-5:0], 4'd0};
      cnt_d = cnt_q - CW'(1);
      if (!sts_o.dec_skip) begin
        wr        = 1'b1;
        chr_d     = CHR_ZERO + {4'd0, top_dig};
        last_d    = cnt_one;
        started_d = 1'b1;
      end
    end
    if (cmd_i.bin_step) begin
      bin_d = {bin_q[W-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (!sts_o.bin_skip) begin
        wr        = 1'b1;
        chr_d     = CHR_ZERO + {7'd0, bin_q[W-1]};
        last_d    = cnt_one;
        started_d = 1'b1;
      end
    end
    ovalid_d = wr || (ovalid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    chr_q  <= chr_d;
    last_q <= last_d;
  end

  assign out_valid_o     = ovalid_q;
  assign out_character_o = chr_q;
  assign out_last_o      = last_q;

  // A converted decimal word holds only valid BCD digits.
  `ITAF_ASSERT_IMP(a_dec_digit_bcd, cmd_i.dec_step, top_dig <= 4'd9)
  // All operand bits have been shifted into the BCD word when conversion ends.
  `ITAF_ASSERT_NXT(a_conv_drained, cmd_i.conv && cnt_one, bin_q == '0)
  // The final position of a run is always printed, never skipped.
  `ITAF_ASSERT_IMP(a_final_emits, (cmd_i.dec_step || cmd_i.bin_step) && cnt_one, out_free)
  // A step that prints only happens when the output register can take it.
  `ITAF_ASSERT_NXT(a_write_lands, wr, ovalid_q && (chr_q == $past(chr_d)))

endmodule
`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
// Order: a character or percent sign is loaded, then written to the output register from ST_SINGLE.
// A decimal request writes a minus sign first when negative (ST_SIGN), converts to BCD in ST_CONV,
// then emits digits in ST_DEC, skipping leading zero positions; binary emits bits in ST_BIN, also skipping them.
// A new request is accepted only in ST_IDLE, after the previous one has emitted its last character;
// a receiver stall holds the FSM in ST_SINGLE, ST_SIGN, ST_DEC and ST_BIN, but not in ST_CONV.
// Reset: rst_ni is asynchronous and active low; it empties the output register and idles the FSM.
`default_nettype none
module integer_to_ascii_formatter import itaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itaf_req_if.sink    req_i,
  itaf_chr_if.source  chr_o
);

  itaf_cmd_t cmd;
  itaf_sts_t sts;
  itaf_op_e  op;

  assign op = itaf_op_e'(req_i.operation);

  itaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (op),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itaf_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .value_i         (req_i.value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (chr_o.valid),
    .out_character_o (chr_o.character),
    .out_last_o      (chr_o.last),
    .out_ready_i     (chr_o.ready)
  );

endmodule
`default_nettype wire

// File: bench/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
  import itaf_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES    = 60;

  typedef struct {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } glyph_t;

  class format_checker;
    glyph_t pending_glyphs[$];
    int     failures;
    int     glyphs_checked;
    int     requests_by_op[4];

    function void put_glyph(logic [CHAR_BITS-1:0] character, logic last);
      glyph_t g;
      g.character = character;
      g.last      = last;
      pending_glyphs.push_back(g);
    endfunction

    function void push_digits(logic [IN_VALUE_BITS-1:0] magnitude,
                              logic [IN_VALUE_BITS-1:0] radix);
      logic [CHAR_BITS-1:0] text[$];
      logic [CHAR_BITS-1:0] digit;
      do begin
        digit = CHR_ZERO + CHAR_BITS'(magnitude % radix);
        text.push_front(digit);
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      foreach (text[i]) put_glyph(text[i], i == text.size() - 1);
    endfunction

    function void note_request(itaf_op_e op, logic [IN_VALUE_BITS-1:0] value);
      logic [IN_VALUE_BITS-1:0] magnitude;
      requests_by_op[op]++;
      case (op)
        OP_CHAR: begin
          put_glyph(value[CHAR_BITS-1:0], 1'b1);
        end
        OP_PERCENT: begin
          put_glyph(CHR_PERCENT, 1'b1);
        end
        OP_SDEC: begin
          magnitude = value;
          if (value[IN_VALUE_BITS-1]) begin
            put_glyph(CHR_MINUS, 1'b0);
            magnitude = -value;
          end
          push_digits(magnitude, 10);
        end
        default: begin
          push_digits(value, 2);
        end
      endcase
    endfunction

    function void check_glyph(logic [CHAR_BITS-1:0] character, logic last);
      glyph_t want;
      glyphs_checked++;
      if (pending_glyphs.size() == 0) begin
        $error("character %h (last %b) arrived with no request outstanding",
               character, last);
        failures++;
        return;
      end
      want = pending_glyphs.pop_front();
      if (want.character !== character) begin
        $error("character: expected %h, actual %h", want.character, character);
        failures++;
      end
      if (want.last !== last) begin
        $error("last: expected %b, actual %b", want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return pending_glyphs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_off_req;
  int   idle_cycles;

  format_checker checker_h;

  itaf_req_if req_if ();
  itaf_chr_if chr_if ();

  integer_to_ascii_formatter i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .chr_o (chr_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_request(input itaf_op_e op, input logic [IN_VALUE_BITS-1:0] value);
    @(negedge clk);
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= value;
    do @(posedge clk); while (!req_if.ready);
    checker_h.note_request(op, value);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_until_drained();
    idle_sender(1);
    while (checker_h.pending() != 0) @(posedge clk);
  endtask

  // The receiver picks a new random stall behavior whenever the current one runs out and
  // honors one long hold-off when asked.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    bit          held;
    chr_if.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        chr_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       chr_if.ready <= 1'b1;
          1:       chr_if.ready <= ($urandom_range(0, 3) != 0);
          2:       chr_if.ready <= ($urandom_range(0, 3) == 0);
          default: chr_if.ready <= (phase % 4 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && chr_if.valid && chr_if.ready) begin
      checker_h.check_glyph(chr_if.character, chr_if.last);
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
      $display("FAIL integer_to_ascii_formatter");
      $finish;
    end
  end

  initial begin
    itaf_op_e                 op;
    logic [IN_VALUE_BITS-1:0] value;
    logic [IN_VALUE_BITS-1:0] power;
    int unsigned              burst_left;
    int unsigned              steady_left;

    checker_h        = new();
    hold_off_req     = 1'b0;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_CHAR;
    req_if.value     <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    send_request(OP_CHAR, 32'h0000_0000);
    send_request(OP_CHAR, 32'h0000_00ff);
    send_request(OP_CHAR, 32'hdead_be41);
    send_request(OP_PERCENT, 32'h0000_0000);
    send_request(OP_PERCENT, 32'hffff_ffff);
    send_request(OP_SDEC, 32'd0);
    send_request(OP_SDEC, 32'd1);
    send_request(OP_SDEC, 32'hffff_ffff);
    send_request(OP_SDEC, 32'd9);
    send_request(OP_SDEC, 32'd10);
    send_request(OP_SDEC, 32'h7fff_ffff);
    send_request(OP_SDEC, 32'h8000_0000);
    send_request(OP_SDEC, 32'h8000_0001);
    send_request(OP_SDEC, 32'd1000000000);
    send_request(OP_SDEC, -32'sd999999999);
    send_request(OP_UBIN, 32'h0000_0000);
    send_request(OP_UBIN, 32'h0000_0001);
    send_request(OP_UBIN, 32'hffff_ffff);
    send_request(OP_UBIN, 32'h8000_0000);
    send_request(OP_UBIN, 32'h5555_5555);
    send_request(OP_UBIN, 32'haaaa_aaaa);
    wait_until_drained();

    burst_left  = 0;
    steady_left = 0;
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 90) begin
        hold_off_req = 1'b1;
        steady_left  = 30;
      end
      if (n == 180) begin
        wait_until_drained();
      end
      if (steady_left != 0) begin
        steady_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 9) >= 3) begin
          idle_sender($urandom_range(1, 8));
        end
      end else begin
        burst_left--;
      end

      case ($urandom_range(0, 9))
        0:       op = OP_CHAR;
        1:       op = OP_PERCENT;
        2, 3, 4, 5: op = OP_SDEC;
        default: op = OP_UBIN;
      endcase

      case ($urandom_range(0, 5))
        0: value = $urandom;
        1: value = $urandom_range(0, 20);
        2: value = 32'h1 << $urandom_range(0, 31);
        3: value = -$urandom_range(1, 20);
        4: begin
          power = 1;
          repeat ($urandom_range(0, 9)) power = power * 10;
          value = power + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1) == 1) value = -value;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       value = 32'h0000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = 32'h8000_0000;
            default: value = 32'hffff_ffff;
          endcase
        end
      endcase
      send_request(op, value);
    end

    idle_sender(1);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d characters: %0d char, %0d percent, %0d decimal, %0d binary requests.",
             checker_h.glyphs_checked, checker_h.requests_by_op[OP_CHAR],
             checker_h.requests_by_op[OP_PERCENT], checker_h.requests_by_op[OP_SDEC],
             checker_h.requests_by_op[OP_UBIN]);
    $display("Included a %0d-cycle receiver hold-off and drained pauses; %0d mismatches seen.",
             HOLD_OFF_CYCLES, checker_h.failures);
    if (checker_h.failures == 0 && checker_h.pending() == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/itaf_pkg.sv
rtl/itaf_if.sv
rtl/itaf_ctrl.sv
rtl/itaf_dp.sv
rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
